@@ hdl/sset_pkg.sv @@
// Shared types and codes for the sorted set block.
// No dependencies; imported by the comparator and the top level.
package sset_pkg;

	localparam int unsigned SSET_CAPACITY = 16;
	localparam int unsigned VALUE_W       = 32;

	// Item kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_INSERT  = 2'd0;
	localparam kind_t KIND_DELETE  = 2'd1;
	localparam kind_t KIND_READOUT = 2'd2;
	localparam kind_t KIND_UNUSED  = 2'd3;

	// Result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_DUPLICATE = 3'd1;
	localparam status_t ST_FULL      = 3'd2;
	localparam status_t ST_DELETED   = 3'd3;
	localparam status_t ST_NOTFOUND  = 3'd4;
	localparam status_t ST_ENTRY     = 3'd5;
	localparam status_t ST_EMPTY     = 3'd6;

	// Comparator flags handed to the sequencer
	typedef struct packed {
		logic eq;
		logic ahead;
	} cmp_res_t;

endpackage

@@ hdl/sorted_set_insert_delete.sv @@
// Top level of the sorted set: sequencer, entry RAM and shared comparator.
// Depends on sset_pkg, sset_ram and sset_cmp.
//
// Keeps up to CAPACITY distinct signed 32-bit values packed in one RAM, in
// ascending order (order_mode 0) or descending order (order_mode 1); a mode
// change leaves stored entries where they are. Each input item is handled
// alone and item_stall stays high until its work is done. An insert or a
// delete scans all stored entries through one comparator, one entry a cycle,
// then moves the entries behind the position one place a cycle through the
// RAM's single read and write ports; a duplicate, a full set or a missing
// value writes nothing. A readout reads each stored entry from the RAM and
// then loads it into the output register, or loads the single empty result
// when the set is empty. The input is free again once the final result is
// loaded; a stalled output holds the sequencer until it can load. Kind 3 is
// taken and dropped with no result. The finished result sits in an output
// register, so the next item can be taken while it waits.
module sorted_set_insert_delete
	import sset_pkg::*;
#(
	parameter int unsigned CAPACITY = SSET_CAPACITY,
	parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,
	// Input items
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [1:0]                kind,
	input  logic signed [VALUE_W-1:0] value,
	// Result items
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [2:0]                status,
	output logic signed [VALUE_W-1:0] entry_value,
	output logic [CNT_W-1:0]          entry_count,
	output logic                      last
);

	localparam int unsigned ADDR_W = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN     = 8'b0000_0010,
		S_DECIDE   = 8'b0000_0100,
		S_SHIFT    = 8'b0000_1000,
		S_FINISH   = 8'b0001_0000,
		S_RESP     = 8'b0010_0000,
		S_EMIT_RD  = 8'b0100_0000,
		S_EMIT_OUT = 8'b1000_0000
	} state_t;

	// Control state
	state_t           state_q;
	logic             order_mode_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;

	// Working registers of the current item
	kind_t                      kind_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic [CNT_W-1:0]           idx_q;
	logic                       cmp_vld_q;
	logic [CNT_W-1:0]           cmp_idx_q;
	logic                       match_q;
	logic [CNT_W-1:0]           mpos_q;
	logic                       ins_found_q;
	logic [CNT_W-1:0]           ipos_q;
	logic [CNT_W-1:0]           pos_q;
	logic [CNT_W-1:0]           sidx_q;
	logic [CNT_W-1:0]           nleft_q;
	logic                       pend_q;
	logic [ADDR_W-1:0]          pend_dst_q;
	status_t                    resp_status_q;

	// Output register payload
	status_t                    status_q;
	logic signed [VALUE_W-1:0]  entry_value_q;
	logic [CNT_W-1:0]           entry_count_q;
	logic                       last_q;

	// Datapath nets
	logic                       accept;
	logic                       out_free;
	logic                       out_load;
	status_t                    out_status_d;
	logic signed [VALUE_W-1:0]  out_value_d;
	logic                       out_last_d;
	logic                       emit_last;
	logic                       scan_more;
	logic [CNT_W-1:0]           ins_pos;
	logic                       ram_wr_en;
	logic [ADDR_W-1:0]          ram_wr_addr;
	logic [VALUE_W-1:0]         ram_wr_data;
	logic [ADDR_W-1:0]          ram_rd_addr;
	logic [VALUE_W-1:0]         ram_rd_data;
	cmp_res_t                   cmp_res;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign emit_last  = ((idx_q + ONE) == count_q);
	assign scan_more  = (idx_q < count_q);
	assign ins_pos    = ins_found_q ? ipos_q : count_q;

	// Entry store
	sset_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Shared comparator: item value against the entry just read
	sset_cmp u_cmp (
		.a      (value_q),
		.b      ($signed(ram_rd_data)),
		.descend(order_mode_q),
		.res    (cmp_res)
	);

	// Drive RAM ports: shift moves read data, finish places an inserted value
	always_comb begin
		ram_rd_addr = (state_q == S_SHIFT) ? sidx_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
		ram_wr_en   = ((state_q == S_SHIFT) && pend_q) ||
		              ((state_q == S_FINISH) && (kind_q == KIND_INSERT));
		ram_wr_addr = (state_q == S_FINISH) ? pos_q[ADDR_W-1:0] : pend_dst_q;
		ram_wr_data = (state_q == S_FINISH) ? value_q : ram_rd_data;
	end

	// Select what goes into the output register
	always_comb begin
		out_load     = 1'b0;
		out_status_d = resp_status_q;
		out_value_d  = '0;
		out_last_d   = 1'b1;
		if ((state_q == S_RESP) && out_free) begin
			out_load = 1'b1;
		end else if ((state_q == S_EMIT_OUT) && out_free) begin
			out_load     = 1'b1;
			out_status_d = ST_ENTRY;
			out_value_d  = $signed(ram_rd_data);
			out_last_d   = emit_last;
		end
	end

	// Sequencer, count and mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			order_mode_q <= 1'b0;
			count_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				order_mode_q <= cfg_wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_INSERT,
							KIND_DELETE:  state_q <= S_SCAN;
							KIND_READOUT: state_q <= (count_q == '0) ? S_RESP : S_EMIT_RD;
							KIND_UNUSED:  state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (!scan_more && !cmp_vld_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (kind_q == KIND_INSERT) begin
						state_q <= (match_q || (count_q >= CAP_CNT)) ? S_RESP : S_SHIFT;
					end else begin
						state_q <= match_q ? S_SHIFT : S_RESP;
					end
				end
				S_SHIFT: begin
					if ((nleft_q == '0) && !pend_q) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					count_q <= (kind_q == KIND_INSERT) ? (count_q + ONE) : (count_q - ONE);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (out_free) begin
						state_q <= emit_last ? S_IDLE : S_EMIT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the item under way
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q        <= kind;
					value_q       <= value;
					idx_q         <= '0;
					cmp_vld_q     <= 1'b0;
					match_q       <= 1'b0;
					ins_found_q   <= 1'b0;
					resp_status_q <= ST_EMPTY;
				end
			end
			S_SCAN: begin
				// Issue one read a cycle, compare the entry read the cycle before
				if (scan_more) begin
					idx_q <= idx_q + ONE;
				end
				cmp_vld_q <= scan_more;
				cmp_idx_q <= idx_q;
				if (cmp_vld_q) begin
					if (cmp_res.eq && !match_q) begin
						match_q <= 1'b1;
						mpos_q  <= cmp_idx_q;
					end
					if (cmp_res.ahead && !ins_found_q) begin
						ins_found_q <= 1'b1;
						ipos_q      <= cmp_idx_q;
					end
				end
			end
			S_DECIDE: begin
				pend_q <= 1'b0;
				if (kind_q == KIND_INSERT) begin
					if (match_q) begin
						resp_status_q <= ST_DUPLICATE;
					end else if (count_q >= CAP_CNT) begin
						resp_status_q <= ST_FULL;
					end else begin
						// Open a gap at the position: move entries up, last first
						resp_status_q <= ST_INSERTED;
						pos_q         <= ins_pos;
						sidx_q        <= count_q - ONE;
						nleft_q       <= count_q - ins_pos;
					end
				end else begin
					if (!match_q) begin
						resp_status_q <= ST_NOTFOUND;
					end else begin
						// Close the gap: move entries behind the match down
						resp_status_q <= ST_DELETED;
						pos_q         <= mpos_q;
						sidx_q        <= mpos_q + ONE;
						nleft_q       <= count_q - mpos_q - ONE;
					end
				end
			end
			S_SHIFT: begin
				// Read one source a cycle, write it one place over next cycle
				if (nleft_q != '0) begin
					nleft_q <= nleft_q - ONE;
					pend_q  <= 1'b1;
					if (kind_q == KIND_INSERT) begin
						pend_dst_q <= ADDR_W'(sidx_q + ONE);
						sidx_q     <= sidx_q - ONE;
					end else begin
						pend_dst_q <= ADDR_W'(sidx_q - ONE);
						sidx_q     <= sidx_q + ONE;
					end
				end else begin
					pend_q <= 1'b0;
				end
			end
			S_EMIT_OUT: begin
				if (out_free) begin
					idx_q <= idx_q + ONE;
				end
			end
			S_FINISH,
			S_RESP,
			S_EMIT_RD: begin
			end
			default: begin
			end
		endcase
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold result payload until the next load
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= out_status_d;
			entry_value_q <= out_value_d;
			entry_count_q <= count_q;
			last_q        <= out_last_d;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign entry_value  = entry_value_q;
	assign entry_count  = entry_count_q;
	assign last         = last_q;

endmodule

@@ hdl/sset_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sset_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/sset_cmp.sv @@
// Shared signed comparator: equality and order under the current direction.
// Depends on sset_pkg for the value width and the flag struct.
module sset_cmp
	import sset_pkg::*;
(
	input  logic signed [VALUE_W-1:0] a,
	input  logic signed [VALUE_W-1:0] b,
	input  logic                      descend,
	output cmp_res_t                  res
);

	// Flag a as equal to b, and a as standing before b
	always_comb begin
		res.eq    = (a == b);
		res.ahead = descend ? (a > b) : (a < b);
	end

endmodule
